// ----- rtl/swpl_pkg.sv -----
// Shared types and constants for the sequence window position lookup.
// Field widths, action and register codes, reset values and the config struct.
// No dependencies.
package swpl_pkg;

    localparam int ACTION_W     = 2;
    localparam int WORD_INDEX_W = 7;
    localparam int WORD_W       = 32;
    localparam int ENTRY_W      = 12;
    localparam int POS_W        = 12;
    localparam int CODE_W       = 31;
    localparam int WIN_W        = 5;
    localparam int SEQ_BITS_W   = 13;
    localparam int OFF_W        = 5;
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;

    localparam int SEQ_WORDS_DEF   = 128;
    localparam int TABLE_DEPTH_DEF = 4096;

    localparam logic [WIN_W-1:0]      WINDOW_BITS_RST   = 5'd16;
    localparam logic [SEQ_BITS_W-1:0] SEQUENCE_BITS_RST = 13'd4096;

    localparam logic [ACTION_W-1:0] ACT_LOAD_WORD  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LOAD_ENTRY = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_LOOKUP     = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_READ_CODE  = 2'd3;

    localparam logic REG_WINDOW_BITS   = 1'b0;
    localparam logic REG_SEQUENCE_BITS = 1'b1;

    typedef struct packed {
        logic [WIN_W-1:0]      window_bits;
        logic [SEQ_BITS_W-1:0] sequence_bits;
    } cfg_t;

endpackage

// ----- rtl/swpl_if.sv -----
// Valid/ready channel interfaces for request and response words.
// Depends on swpl_pkg for field widths.
interface swpl_req_if;
    logic                              valid;
    logic                              ready;
    logic [swpl_pkg::ACTION_W-1:0]     action;
    logic [swpl_pkg::WORD_INDEX_W-1:0] word_index;
    logic [swpl_pkg::WORD_W-1:0]       word_value;
    logic [swpl_pkg::ENTRY_W-1:0]      entry_index;
    logic [swpl_pkg::POS_W-1:0]        entry_position;
    logic [swpl_pkg::CODE_W-1:0]       query_code;
    logic [swpl_pkg::POS_W-1:0]        query_position;

    modport source (
        output valid, action, word_index, word_value, entry_index, entry_position,
               query_code, query_position,
        input  ready
    );
    modport sink (
        input  valid, action, word_index, word_value, entry_index, entry_position,
               query_code, query_position,
        output ready
    );
endinterface

interface swpl_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         found;
    logic [swpl_pkg::POS_W-1:0]   position;
    logic [swpl_pkg::CODE_W-1:0]  code;

    modport source (
        output valid, found, position, code,
        input  ready
    );
    modport sink (
        input  valid, found, position, code,
        output ready
    );
endinterface

// ----- rtl/sequence_window_position_lookup.sv -----
// Top level of the sequence window position lookup: search control and stores.
// Depends on swpl_pkg, swpl_if, swpl_ram and swpl_cfg.
//
// Usage:
//   request  - valid/ready words: load a sequence word, load a sorted table slot,
//              look up a code, or read the code at a bit position.
//   response - one word per lookup or read: found, position, code.
//   APB port - window_bits at 0x0, sequence_bits at 0x4; write only while idle.
// Sequencing:
//   Loads leave the block idle and give no response word.
//   A read passes S_SADDR, S_CMP and S_DONE before the next acceptance.
//   A lookup makes at most 13 probes over 4096 slots. Each probe reads the
//   table RAM, then the two sequence banks, then compares.
// Reset:
//   Control state and the output valid flag clear; the sequence and table RAMs
//   hold nothing defined until loaded. Registers return to 16 and 4096.
// Stall:
//   A finished word waits in the output register; the next request is taken
//   meanwhile, and a second result waits in its final state until the output
//   register frees.
module sequence_window_position_lookup #(
    parameter int SEQ_WORDS   = swpl_pkg::SEQ_WORDS_DEF,
    parameter int TABLE_DEPTH = swpl_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    swpl_req_if.sink                      request,
    swpl_rsp_if.source                    response,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [swpl_pkg::PADDR_W-1:0]  paddr,
    input  logic [swpl_pkg::PDATA_W-1:0]  pwdata,
    output logic [swpl_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    localparam int TAW        = $clog2(TABLE_DEPTH);
    localparam int IW         = ((TAW > swpl_pkg::SEQ_BITS_W) ? TAW : swpl_pkg::SEQ_BITS_W) + 2;
    localparam int EVEN_DEPTH = (SEQ_WORDS + 1) / 2;
    localparam int ODD_DEPTH  = SEQ_WORDS / 2;
    localparam int EAW        = (EVEN_DEPTH > 1) ? $clog2(EVEN_DEPTH) : 1;
    localparam int OAW        = (ODD_DEPTH > 1) ? $clog2(ODD_DEPTH) : 1;
    localparam int IDX_W      = swpl_pkg::POS_W - swpl_pkg::OFF_W;

    localparam logic signed [IW-1:0] ONE_S = IW'(1);
    localparam logic signed [IW-1:0] TOP_S = IW'(TABLE_DEPTH - 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_TADDR = 5'b00010,
        S_SADDR = 5'b00100,
        S_CMP   = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    swpl_pkg::cfg_t cfg;

    state_t                          state_reg, state_next;
    logic                            lookup_reg, lookup_next;
    logic [swpl_pkg::CODE_W-1:0]     target_reg, target_next;
    logic signed [IW-1:0]            lo_reg, lo_next;
    logic signed [IW-1:0]            hi_reg, hi_next;
    logic [TAW-1:0]                  mid_reg, mid_next;
    logic [swpl_pkg::POS_W-1:0]      pos_reg, pos_next;
    logic                            par_reg, par_next;
    logic                            low_ok_reg, low_ok_next;
    logic                            up_ok_reg, up_ok_next;
    logic                            res_found_reg, res_found_next;
    logic [swpl_pkg::POS_W-1:0]      res_pos_reg, res_pos_next;
    logic [swpl_pkg::CODE_W-1:0]     res_code_reg, res_code_next;
    logic                            out_valid_reg, out_valid_next;
    logic                            out_found_reg, out_found_next;
    logic [swpl_pkg::POS_W-1:0]      out_pos_reg, out_pos_next;
    logic [swpl_pkg::CODE_W-1:0]     out_code_reg, out_code_next;

    logic                            accept;
    logic                            seq_we_even, seq_we_odd, tbl_we;
    logic [swpl_pkg::POS_W-1:0]      tbl_rdata;
    logic [swpl_pkg::WORD_W-1:0]     even_rdata, odd_rdata;
    logic [swpl_pkg::POS_W-1:0]      src_pos;
    logic [IDX_W-1:0]                idx;
    logic [IDX_W:0]                  idx_up;
    logic [swpl_pkg::WORD_W-1:0]     word_low, word_up;
    logic [2*swpl_pkg::WORD_W-1:0]   word_pair;
    logic [2*swpl_pkg::WORD_W-1:0]   shifted;
    logic [swpl_pkg::CODE_W-1:0]     win_code;
    logic signed [IW-1:0]            sum;
    logic [TAW-1:0]                  mid_calc;
    logic signed [IW-1:0]            mid_s;
    logic signed [IW-1:0]            span;
    logic                            too_short;

    swpl_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign request.ready = (state_reg == S_IDLE);
    assign accept        = request.valid & request.ready;

    assign seq_we_even = accept && (request.action == swpl_pkg::ACT_LOAD_WORD)
                         && (32'(request.word_index) < SEQ_WORDS) && !request.word_index[0];
    assign seq_we_odd  = accept && (request.action == swpl_pkg::ACT_LOAD_WORD)
                         && (32'(request.word_index) < SEQ_WORDS) && request.word_index[0];
    assign tbl_we      = accept && (request.action == swpl_pkg::ACT_LOAD_ENTRY)
                         && (32'(request.entry_index) < TABLE_DEPTH);

    assign sum      = lo_reg + hi_reg;
    assign mid_calc = TAW'(sum[IW-1:1]);
    assign mid_s    = IW'(mid_reg);

    assign src_pos = lookup_reg ? tbl_rdata : pos_reg;
    assign idx     = src_pos[swpl_pkg::POS_W-1:swpl_pkg::OFF_W];
    assign idx_up  = {1'b0, idx} + (IDX_W + 1)'(1);

    swpl_ram #(
        .WIDTH  (swpl_pkg::POS_W),
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (TAW)
    ) u_tbl_ram (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (TAW'(request.entry_index)),
        .wdata (request.entry_position),
        .raddr (mid_calc),
        .rdata (tbl_rdata)
    );

    swpl_ram #(
        .WIDTH  (swpl_pkg::WORD_W),
        .DEPTH  (EVEN_DEPTH),
        .ADDR_W (EAW)
    ) u_seq_even_ram (
        .clk   (clk),
        .we    (seq_we_even),
        .waddr (EAW'(request.word_index >> 1)),
        .wdata (request.word_value),
        .raddr (EAW'(idx_up >> 1)),
        .rdata (even_rdata)
    );

    swpl_ram #(
        .WIDTH  (swpl_pkg::WORD_W),
        .DEPTH  (ODD_DEPTH),
        .ADDR_W (OAW)
    ) u_seq_odd_ram (
        .clk   (clk),
        .we    (seq_we_odd),
        .waddr (OAW'(request.word_index >> 1)),
        .wdata (request.word_value),
        .raddr (OAW'(idx >> 1)),
        .rdata (odd_rdata)
    );

    assign word_low  = low_ok_reg ? (par_reg ? odd_rdata : even_rdata) : '0;
    assign word_up   = up_ok_reg ? (par_reg ? even_rdata : odd_rdata) : '0;
    assign word_pair = {word_up, word_low};
    assign shifted   = word_pair >> pos_reg[swpl_pkg::OFF_W-1:0];
    assign win_code  = shifted[swpl_pkg::CODE_W-1:0]
                       & ~({swpl_pkg::CODE_W{1'b1}} << cfg.window_bits);

    assign span      = IW'(cfg.sequence_bits) - IW'(cfg.window_bits);
    assign too_short = cfg.sequence_bits < swpl_pkg::SEQ_BITS_W'(cfg.window_bits);

    always_comb
    begin
        state_next     = state_reg;
        lookup_next    = lookup_reg;
        target_next    = target_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        pos_next       = pos_reg;
        par_next       = par_reg;
        low_ok_next    = low_ok_reg;
        up_ok_next     = up_ok_reg;
        res_found_next = res_found_reg;
        res_pos_next   = res_pos_reg;
        res_code_next  = res_code_reg;
        out_valid_next = out_valid_reg && !response.ready;
        out_found_next = out_found_reg;
        out_pos_next   = out_pos_reg;
        out_code_next  = out_code_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (request.action)
                        swpl_pkg::ACT_LOOKUP:
                        begin
                            lookup_next = 1'b1;
                            target_next = request.query_code;
                            if (too_short)
                            begin
                                res_found_next = 1'b0;
                                res_pos_next   = '0;
                                res_code_next  = '0;
                                state_next     = S_DONE;
                            end
                            else
                            begin
                                lo_next    = '0;
                                hi_next    = (span > TOP_S) ? TOP_S : span;
                                state_next = S_TADDR;
                            end
                        end
                        swpl_pkg::ACT_READ_CODE:
                        begin
                            lookup_next = 1'b0;
                            pos_next    = request.query_position;
                            state_next  = S_SADDR;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_TADDR:
            begin
                if (lo_reg > hi_reg)
                begin
                    res_found_next = 1'b0;
                    res_pos_next   = '0;
                    res_code_next  = '0;
                    state_next     = S_DONE;
                end
                else
                begin
                    mid_next   = mid_calc;
                    state_next = S_SADDR;
                end
            end
            S_SADDR:
            begin
                pos_next    = src_pos;
                par_next    = idx[0];
                low_ok_next = 32'(idx) < SEQ_WORDS;
                up_ok_next  = 32'(idx_up) < SEQ_WORDS;
                state_next  = S_CMP;
            end
            S_CMP:
            begin
                if (!lookup_reg || (target_reg == win_code))
                begin
                    res_found_next = 1'b1;
                    res_pos_next   = pos_reg;
                    res_code_next  = win_code;
                    state_next     = S_DONE;
                end
                else if (target_reg > win_code)
                begin
                    lo_next    = mid_s + ONE_S;
                    state_next = S_TADDR;
                end
                else
                begin
                    hi_next    = mid_s - ONE_S;
                    state_next = S_TADDR;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || response.ready)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = res_found_reg;
                    out_pos_next   = res_pos_reg;
                    out_code_next  = res_code_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lookup_reg    <= lookup_next;
        target_reg    <= target_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        pos_reg       <= pos_next;
        par_reg       <= par_next;
        low_ok_reg    <= low_ok_next;
        up_ok_reg     <= up_ok_next;
        res_found_reg <= res_found_next;
        res_pos_reg   <= res_pos_next;
        res_code_reg  <= res_code_next;
        out_found_reg <= out_found_next;
        out_pos_reg   <= out_pos_next;
        out_code_reg  <= out_code_next;
    end

    assign response.valid    = out_valid_reg;
    assign response.found    = out_found_reg;
    assign response.position = out_pos_reg;
    assign response.code     = out_code_reg;

    a_mid_in_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_SADDR) && lookup_reg |-> (mid_s >= lo_reg) && (mid_s <= hi_reg)
    ) else $error("probe index outside search bounds");

    a_bounds_order: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_TADDR) |-> (lo_reg <= hi_reg) || (lo_reg == hi_reg + ONE_S)
    ) else $error("search bounds crossed by more than one slot");

    a_done_drains: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) && !out_valid_reg |=> out_valid_reg && (state_reg == S_IDLE)
    ) else $error("finished result not moved to output register");

    a_read_found: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) && !lookup_reg |-> res_found_reg
    ) else $error("read result without found flag");

endmodule

// ----- rtl/swpl_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module swpl_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/swpl_cfg.sv -----
// APB-style configuration registers: window_bits and sequence_bits.
// Depends on swpl_pkg for register codes, reset values and cfg_t.
module swpl_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [swpl_pkg::PADDR_W-1:0]   paddr,
    input  logic [swpl_pkg::PDATA_W-1:0]   pwdata,
    output logic [swpl_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    output swpl_pkg::cfg_t                 cfg
);

    logic                                 reg_index;
    logic                                 wr_en;
    logic [swpl_pkg::WIN_W-1:0]           window_bits_reg;
    logic [swpl_pkg::WIN_W-1:0]           window_bits_next;
    logic [swpl_pkg::SEQ_BITS_W-1:0]      sequence_bits_reg;
    logic [swpl_pkg::SEQ_BITS_W-1:0]      sequence_bits_next;

    assign pready    = 1'b1;
    assign reg_index = paddr[2];
    assign wr_en     = psel & penable & pwrite & pready;

    always_comb
    begin
        window_bits_next   = window_bits_reg;
        sequence_bits_next = sequence_bits_reg;
        prdata             = '0;
        case (reg_index)
            swpl_pkg::REG_WINDOW_BITS:
            begin
                prdata = swpl_pkg::PDATA_W'(window_bits_reg);
                if (wr_en)
                begin
                    window_bits_next = pwdata[swpl_pkg::WIN_W-1:0];
                end
            end
            swpl_pkg::REG_SEQUENCE_BITS:
            begin
                prdata = swpl_pkg::PDATA_W'(sequence_bits_reg);
                if (wr_en)
                begin
                    sequence_bits_next = pwdata[swpl_pkg::SEQ_BITS_W-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_bits_reg   <= swpl_pkg::WINDOW_BITS_RST;
            sequence_bits_reg <= swpl_pkg::SEQUENCE_BITS_RST;
        end
        else
        begin
            window_bits_reg   <= window_bits_next;
            sequence_bits_reg <= sequence_bits_next;
        end
    end

    assign cfg.window_bits   = window_bits_reg;
    assign cfg.sequence_bits = sequence_bits_reg;

endmodule

// ----- test/swpl_lookup_checker.sv -----
// Watches the request, response and APB traffic of the window position lookup,
// predicts each response word and compares it field by field.
// Depends on swpl_pkg and the swpl_req_if / swpl_rsp_if interfaces.
`timescale 1ns / 100ps

module swpl_lookup_checker
    import swpl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    swpl_req_if                request,
    swpl_rsp_if                response,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    input  logic [PDATA_W-1:0] prdata,
    output int                 fail_count,
    output int                 waiting,
    output int                 hit_count,
    output int                 miss_count,
    output int                 read_count
);

    typedef struct packed {
        logic              found;
        logic [POS_W-1:0]  position;
        logic [CODE_W-1:0] code;
    } answer_t;

    logic [WORD_W-1:0]     seq_store [SEQ_WORDS_DEF];
    logic [POS_W-1:0]      slot_store [TABLE_DEPTH_DEF];
    logic [WIN_W-1:0]      win_bits;
    logic [SEQ_BITS_W-1:0] seq_bits;
    answer_t               results_due [$];

    initial
    begin
        fail_count = 0;
        waiting    = 0;
        hit_count  = 0;
        miss_count = 0;
        read_count = 0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] wanted);
        fail_count++;
        if (fail_count <= 200)
            $display("mismatch at %0t: %0s got %0h wanted %0h", $realtime, what, got, wanted);
    endtask

    function automatic logic [WORD_W-1:0] fetch_word(input int idx);
        if (idx < SEQ_WORDS_DEF)
            return seq_store[idx];
        return '0;
    endfunction

    function automatic logic [CODE_W-1:0] window_code(input logic [POS_W-1:0] pos);
        int          idx;
        int          off;
        logic [31:0] v;
        logic [31:0] mask;
        idx = int'(pos >> OFF_W);
        off = int'(pos[OFF_W-1:0]);
        v = fetch_word(idx) >> off;
        if (off != 0 && off + int'(win_bits) > 32)
            v = v | (fetch_word(idx + 1) << (32 - off));
        mask = (32'd1 << win_bits) - 32'd1;
        return CODE_W'(v & mask);
    endfunction

    function automatic answer_t search_slots(input logic [CODE_W-1:0] target);
        answer_t           ans;
        int                lo;
        int                hi;
        int                mid;
        logic [POS_W-1:0]  p;
        logic [CODE_W-1:0] c;
        ans = '0;
        if (seq_bits < win_bits)
            return ans;
        lo = 0;
        hi = int'(seq_bits) - int'(win_bits);
        if (hi > TABLE_DEPTH_DEF - 1)
            hi = TABLE_DEPTH_DEF - 1;
        while (lo <= hi)
        begin
            mid = (lo + hi) / 2;
            p = slot_store[mid];
            c = window_code(p);
            if (target > c)
                lo = mid + 1;
            else if (target < c)
                hi = mid - 1;
            else
            begin
                ans.found    = 1'b1;
                ans.position = p;
                ans.code     = target;
                return ans;
            end
        end
        return ans;
    endfunction

    always @(posedge clk)
    begin
        answer_t due;
        if (!rst_n)
        begin
            win_bits = WINDOW_BITS_RST;
            seq_bits = SEQUENCE_BITS_RST;
        end
        else
        begin
            if (psel && penable && pready)
            begin
                if (pwrite && paddr[PADDR_W-1] == REG_WINDOW_BITS)
                    win_bits = pwdata[WIN_W-1:0];
                else if (pwrite)
                    seq_bits = pwdata[SEQ_BITS_W-1:0];
                else if (paddr[PADDR_W-1] == REG_WINDOW_BITS && prdata !== PDATA_W'(win_bits))
                    report_mismatch("window_bits readback", prdata, PDATA_W'(win_bits));
                else if (paddr[PADDR_W-1] == REG_SEQUENCE_BITS
                         && prdata !== PDATA_W'(seq_bits))
                    report_mismatch("sequence_bits readback", prdata, PDATA_W'(seq_bits));
            end

            if (response.valid && response.ready)
            begin
                if (results_due.size() == 0)
                    report_mismatch("response word with nothing due", 32'd0, 32'd0);
                else
                begin
                    due = results_due.pop_front();
                    if (response.found !== due.found)
                        report_mismatch("found", response.found, due.found);
                    if (response.position !== due.position)
                        report_mismatch("position", response.position, due.position);
                    if (response.code !== due.code)
                        report_mismatch("code", response.code, due.code);
                end
            end

            if (request.valid && request.ready)
            begin
                case (request.action)
                    ACT_LOAD_WORD:
                        if (int'(request.word_index) < SEQ_WORDS_DEF)
                            seq_store[request.word_index] = request.word_value;
                    ACT_LOAD_ENTRY:
                        slot_store[request.entry_index] = request.entry_position;
                    ACT_LOOKUP:
                    begin
                        due = search_slots(request.query_code);
                        results_due.push_back(due);
                        if (due.found)
                            hit_count++;
                        else
                            miss_count++;
                    end
                    ACT_READ_CODE:
                    begin
                        due.found    = 1'b1;
                        due.position = request.query_position;
                        due.code     = window_code(request.query_position);
                        results_due.push_back(due);
                        read_count++;
                    end
                    default: ;
                endcase
            end
        end
        waiting <= results_due.size();
    end

endmodule

// ----- test/tb_top.sv -----
// Top of the window position lookup testbench: clock, reset, APB setup, request
// and response drivers, phase sequencing and verdict. Depends on swpl_pkg, the
// channel interfaces, the lookup RTL and swpl_lookup_checker.
`timescale 1ns / 100ps

module tb_top;
    import swpl_pkg::*;

    localparam int LIMIT    = 1_000_000;
    localparam int SETTLE   = 48;
    localparam int HOLD_OFF = 400;

    typedef struct packed {
        logic [ACTION_W-1:0]     action;
        logic [WORD_INDEX_W-1:0] word_index;
        logic [WORD_W-1:0]       word_value;
        logic [ENTRY_W-1:0]      entry_index;
        logic [POS_W-1:0]        entry_position;
        logic [CODE_W-1:0]       query_code;
        logic [POS_W-1:0]        query_position;
    } req_word_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int   fail_count;
    int   waiting;
    int   hit_count;
    int   miss_count;
    int   read_count;
    int   cycles      = 0;
    int   idle_odds   = 4;
    logic stall_hold  = 1'b0;
    logic pressure_go = 1'b0;

    logic [WORD_W-1:0]     words_shadow [SEQ_WORDS_DEF];
    logic [POS_W-1:0]      slots_shadow [TABLE_DEPTH_DEF];
    logic [WIN_W-1:0]      win_now;
    logic [SEQ_BITS_W-1:0] seq_now;
    int                    top_slot = -1;

    swpl_req_if request_ch ();
    swpl_rsp_if response_ch ();

    sequence_window_position_lookup DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request_ch),
        .response (response_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    swpl_lookup_checker lookup_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .request    (request_ch),
        .response   (response_ch),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .fail_count (fail_count),
        .waiting    (waiting),
        .hit_count  (hit_count),
        .miss_count (miss_count),
        .read_count (read_count)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    // response side: random stall bursts, plus one long hold-off
    initial
    begin
        int gap;
        gap = 0;
        response_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (gap > 0)
                gap--;
            else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
                gap = $urandom_range(1, 17);
            response_ch.ready <= (gap == 0) && !stall_hold;
        end
    end

    initial
    begin
        wait (pressure_go);
        @(posedge clk);
        stall_hold <= 1'b1;
        repeat (HOLD_OFF) @(posedge clk);
        stall_hold <= 1'b0;
    end

    function automatic logic [CODE_W-1:0] shadow_code(input int pos);
        logic [63:0]       pair;
        logic [WORD_W-1:0] upper;
        int                idx;
        idx = pos / 32;
        upper = (idx + 1 < SEQ_WORDS_DEF) ? words_shadow[idx + 1] : '0;
        pair = {upper, words_shadow[idx]} >> (pos % 32);
        return CODE_W'(pair[31:0] & ((32'd1 << win_now) - 32'd1));
    endfunction

    function automatic req_word_t make_word(input logic [ACTION_W-1:0] act);
        req_word_t w;
        w.action         = act;
        w.word_index     = WORD_INDEX_W'($urandom);
        w.word_value     = $urandom;
        w.entry_index    = ENTRY_W'($urandom);
        w.entry_position = POS_W'($urandom);
        w.query_code     = CODE_W'($urandom);
        w.query_position = POS_W'($urandom);
        return w;
    endfunction

    task automatic push_word(input req_word_t w);
        int gap;
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
        begin
            gap = $urandom_range(1, 17);
            request_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        request_ch.valid          <= 1'b1;
        request_ch.action         <= w.action;
        request_ch.word_index     <= w.word_index;
        request_ch.word_value     <= w.word_value;
        request_ch.entry_index    <= w.entry_index;
        request_ch.entry_position <= w.entry_position;
        request_ch.query_code     <= w.query_code;
        request_ch.query_position <= w.query_position;
        @(posedge clk);
        while (!request_ch.ready)
            @(posedge clk);
    endtask

    task automatic send_seq(input int idx, input logic [WORD_W-1:0] value);
        req_word_t w;
        w = make_word(ACT_LOAD_WORD);
        w.word_index = WORD_INDEX_W'(idx);
        w.word_value = value;
        words_shadow[idx] = value;
        push_word(w);
    endtask

    task automatic send_entry(input int idx, input logic [POS_W-1:0] pos);
        req_word_t w;
        w = make_word(ACT_LOAD_ENTRY);
        w.entry_index    = ENTRY_W'(idx);
        w.entry_position = pos;
        slots_shadow[idx] = pos;
        push_word(w);
    endtask

    task automatic send_lookup(input logic [CODE_W-1:0] target);
        req_word_t w;
        w = make_word(ACT_LOOKUP);
        w.query_code = target;
        push_word(w);
    endtask

    task automatic send_read(input logic [POS_W-1:0] pos);
        req_word_t w;
        w = make_word(ACT_READ_CODE);
        w.query_position = pos;
        push_word(w);
    endtask

    task automatic apb_access(input logic wr, input logic reg_sel,
                              input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // drop valid, drain every response word, then let trailing loads retire
    task automatic settle();
        request_ch.valid <= 1'b0;
        @(posedge clk);
        while (waiting != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_config(input int w, input int s);
        logic [PDATA_W-1:0] junk;
        settle();
        junk = $urandom;
        apb_access(1'b1, REG_WINDOW_BITS, {junk[PDATA_W-1:WIN_W], WIN_W'(w)});
        junk = $urandom;
        apb_access(1'b1, REG_SEQUENCE_BITS, {junk[PDATA_W-1:SEQ_BITS_W], SEQ_BITS_W'(s)});
        apb_access(1'b0, REG_WINDOW_BITS, '0);
        apb_access(1'b0, REG_SEQUENCE_BITS, '0);
        win_now = WIN_W'(w);
        seq_now = SEQ_BITS_W'(s);
        if (s < w)
            top_slot = -1;
        else if (s - w > TABLE_DEPTH_DEF - 1)
            top_slot = TABLE_DEPTH_DEF - 1;
        else
            top_slot = s - w;
    endtask

    // load slots 0..top_slot, ordered by window code unless a broken table is wanted
    task automatic fill_slots(input bit ordered);
        longint unsigned keys [$];
        int              p;
        for (int k = 0; k <= top_slot; k++)
        begin
            p = $urandom_range(0, TABLE_DEPTH_DEF - 1);
            keys.push_back((longint'(shadow_code(p)) << POS_W) | longint'(p));
        end
        if (ordered)
            keys.sort();
        for (int k = 0; k < keys.size(); k++)
            send_entry(k, POS_W'(keys[k]));
    endtask

    task automatic random_item();
        int          r;
        logic [31:0] mask;
        r = $urandom_range(0, 99);
        mask = (32'd1 << win_now) - 32'd1;
        if (r < 40 && top_slot >= 0)
            send_lookup(shadow_code(slots_shadow[$urandom_range(0, top_slot)]));
        else if (r < 55)
            send_lookup(($urandom_range(0, 3) == 0) ? CODE_W'($urandom)
                                                     : CODE_W'($urandom & mask));
        else if (r < 88)
            send_read(POS_W'($urandom));
        else if (r < 95)
            send_entry($urandom_range(0, TABLE_DEPTH_DEF - 1), POS_W'($urandom));
        else
            send_seq($urandom_range(0, SEQ_WORDS_DEF - 1), $urandom);
    endtask

    task automatic run_phase(input int w, input int s, input int count,
                             input bit ordered, input bit refill);
        set_config(w, s);
        if (refill)
            fill_slots(ordered);
        repeat (count) random_item();
    endtask

    initial
    begin
        int w;
        int s;
        int lo;
        int hi;
        rst_n                     = 1'b0;
        psel                      = 1'b0;
        penable                   = 1'b0;
        pwrite                    = 1'b0;
        paddr                     = '0;
        pwdata                    = '0;
        request_ch.valid          = 1'b0;
        request_ch.action         = ACT_LOAD_WORD;
        request_ch.word_index     = '0;
        request_ch.word_value     = '0;
        request_ch.entry_index    = '0;
        request_ch.entry_position = '0;
        request_ch.query_code     = '0;
        request_ch.query_position = '0;
        win_now                   = WINDOW_BITS_RST;
        seq_now                   = SEQUENCE_BITS_RST;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the whole sequence store, extremes in the first two words
        send_seq(0, 32'h0000_0000);
        send_seq(1, 32'hFFFF_FFFF);
        for (int k = 2; k < SEQ_WORDS_DEF; k++)
            send_seq(k, $urandom);

        // reads under the reset window size, including the window past the store
        send_read(12'd0);
        send_read(12'd31);
        send_read(12'd40);
        send_read(12'd4064);
        send_read(12'd4095);

        // sequence shorter than the window
        set_config(31, 30);
        send_lookup(31'd0);
        send_lookup(31'h7FFF_FFFF);
        send_read(12'd1);
        send_read(12'd33);

        // single-slot table
        set_config(1, 1);
        send_entry(0, 12'd32);
        send_entry(TABLE_DEPTH_DEF - 1, 12'hFFF);
        send_lookup(31'd1);
        send_lookup(31'd0);
        send_read(12'd0);
        send_read(12'd4095);

        for (int ph = 0; ph < 10; ph++)
        begin
            w = $urandom_range(1, 31);
            if (ph % 4 == 3)
                s = $urandom_range(1, w);
            else
                s = w + $urandom_range(0, 60);
            idle_odds = (ph % 3 == 2) ? 0 : $urandom_range(2, 6);
            run_phase(w, s, 60, $urandom_range(0, 5) != 0, 1'b1);
            if (ph == 5)
            begin
                pressure_go = 1'b1;
                repeat (40) send_read(POS_W'($urandom));
            end
        end

        // zero window over the clamped range: every code is 0, so only the middle
        // slot and the slots on the upper search path are probed
        idle_odds = 0;
        set_config(0, 4096);
        lo = 0;
        hi = TABLE_DEPTH_DEF - 1;
        while (lo <= hi)
        begin
            send_entry((lo + hi) / 2, POS_W'($urandom));
            lo = (lo + hi) / 2 + 1;
        end
        for (int k = 0; k < 20; k++)
        begin
            send_lookup(31'd0);
            send_lookup(CODE_W'($urandom_range(1, 32'h7FFF_FFFF)));
            send_read(POS_W'($urandom));
        end

        settle();
        $display("covered %0d lookups (%0d found, %0d not found) and %0d code reads",
                 hit_count + miss_count, hit_count, miss_count, read_count);
        $display("window sizes 0, 1, 31 and random; sequence lengths 1 to 4096; long stall");
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
